// ===== hdl/scpb_pkg.sv =====
// Shared types and codes for the spoken clock phrase builder.
// Holds the request classes, the queued phrase descriptor, clip folder and
// word codes, and the sequencer step type. No dependencies.
package scpb_pkg;

	// Queue depth default for the front-to-back descriptor queue
	localparam int SCPB_QUEUE_DEPTH = 8;

	// Request function codes
	localparam logic [1:0] FUNC_ANNOUNCE = 2'd0;
	localparam logic [1:0] FUNC_ALARM    = 2'd1;
	localparam logic [1:0] FUNC_EFFECT   = 2'd2;

	// Clip folders
	localparam logic [2:0] FOLD_WORDS  = 3'd1;
	localparam logic [2:0] FOLD_TENS   = 3'd2;
	localparam logic [2:0] FOLD_DIGITS = 3'd3;
	localparam logic [2:0] FOLD_ALARM  = 3'd4;
	localparam logic [2:0] FOLD_EFFECT = 3'd5;

	// Clips in the words folder
	localparam logic [4:0] W_YEAR      = 5'd1;
	localparam logic [4:0] W_MONTH     = 5'd2;
	localparam logic [4:0] W_DAY       = 5'd3;
	localparam logic [4:0] W_MINUTE    = 5'd5;
	localparam logic [4:0] W_MORNING   = 5'd7;
	localparam logic [4:0] W_AFTERNOON = 5'd8;
	localparam logic [4:0] W_WHOLE     = 5'd9;
	localparam logic [4:0] W_DIAN      = 5'd14;
	localparam logic [4:0] W_NOW       = 5'd15;
	localparam logic [4:0] W_WEEK      = 5'd16;
	localparam logic [4:0] W_PAUSE     = 5'd17;

	// Clip in the tens folder
	localparam logic [4:0] T_TEN = 5'd1;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_ANNOUNCE,
		KIND_ALARM,
		KIND_EFFECT
	} scpb_kind_t;

	// A number below 64 split into tens and units
	typedef struct packed {
		logic [2:0] t;
		logic [3:0] u;
	} scpb_num_t;

	// One classified request as it waits in the queue
	typedef struct packed {
		scpb_kind_t kind;
		logic [3:0] snd_clip;
		logic [3:0] yd3;
		logic [3:0] yd2;
		logic [3:0] yd1;
		logic [3:0] yd0;
		scpb_num_t  month;
		scpb_num_t  date;
		scpb_num_t  hour;
		scpb_num_t  minute;
		logic [2:0] wday;
		logic       ampm;
		logic       pm;
	} scpb_entry_t;

	typedef enum logic [4:0] {
		STEP_SOUND,
		STEP_NOW,
		STEP_P0,
		STEP_Y3,
		STEP_Y2,
		STEP_Y1,
		STEP_Y0,
		STEP_YEARW,
		STEP_MON_T,
		STEP_MON_TEN,
		STEP_MON_U,
		STEP_MONW,
		STEP_DAT_T,
		STEP_DAT_TEN,
		STEP_DAT_U,
		STEP_DAYW,
		STEP_P1,
		STEP_WEEK,
		STEP_WDAY,
		STEP_P2,
		STEP_AMPM,
		STEP_HR_T,
		STEP_HR_TEN,
		STEP_HR_U,
		STEP_DIAN,
		STEP_WHOLE,
		STEP_MIN_Z,
		STEP_MIN_T,
		STEP_MIN_TEN,
		STEP_MIN_U,
		STEP_MINW,
		STEP_P3
	} scpb_step_t;

endpackage

// ===== hdl/scpb_front.sv =====
// Front end of the phrase builder: three-stage classify and digit split.
// Turns an accepted request into a queue descriptor. Depends on scpb_pkg.
module scpb_front import scpb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [1:0]  func,
	input  logic [13:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day_of_month,
	input  logic [2:0]  weekday,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [7:0]  sound_index,
	input  logic        twelve_hour_mode,
	output logic        push,
	output scpb_entry_t entry,
	output logic [1:0]  inflight
);

	// Split a value below 64 into tens and units
	function automatic scpb_num_t split_num(input logic [5:0] n);
		scpb_num_t  r;
		logic [5:0] base;
		r.t  = '0;
		base = '0;
		for (int k = 1; k <= 6; k++) begin
			if (n >= 6'(k * 10)) begin
				r.t  = 3'(k);
				base = 6'(k * 10);
			end
		end
		r.u = 4'(n - base);
		return r;
	endfunction

	// Stage 1: captured request
	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [13:0] year_s1;
	logic [3:0]  month_s1;
	logic [4:0]  date_s1;
	logic [2:0]  wday_s1;
	logic [4:0]  hour_s1;
	logic [5:0]  minute_s1;
	logic [7:0]  snd_s1;
	logic        mode_s1;

	scpb_kind_t  kind_c;
	logic [4:0]  yk_c;
	logic [13:0] thou_c;
	logic [9:0]  r1_c;
	logic [4:0]  hsp_c;
	logic        pm_c;
	logic [3:0]  sclip_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1   <= func;
			year_s1   <= year;
			month_s1  <= month;
			date_s1   <= day_of_month;
			wday_s1   <= weekday;
			hour_s1   <= hour;
			minute_s1 <= minute;
			snd_s1    <= sound_index;
			mode_s1   <= twelve_hour_mode;
		end
	end

	always_comb begin
		case (func_s1)
			FUNC_ANNOUNCE: kind_c = KIND_ANNOUNCE;
			FUNC_ALARM:    kind_c = KIND_ALARM;
			FUNC_EFFECT:   kind_c = KIND_EFFECT;
			default:       kind_c = KIND_NONE;
		endcase
		// thousands by parallel compares against the multiples of 1000
		yk_c   = '0;
		thou_c = '0;
		for (int k = 1; k <= 16; k++) begin
			if (year_s1 >= 14'(k * 1000)) begin
				yk_c   = 5'(k);
				thou_c = 14'(k * 1000);
			end
		end
		r1_c = 10'(year_s1 - thou_c);
		// twelve-hour conversion
		pm_c = (hour_s1 >= 5'd12);
		if (mode_s1 && hour_s1 == 5'd0) begin
			hsp_c = 5'd12;
		end else if (mode_s1 && hour_s1 > 5'd12) begin
			hsp_c = hour_s1 - 5'd12;
		end else begin
			hsp_c = hour_s1;
		end
		sclip_c = (snd_s1 > 8'd9) ? 4'd10 : (snd_s1[3:0] + 4'd1);
	end

	// Stage 2: thousands done, hour converted
	logic        valid_s2;
	scpb_kind_t  kind_s2;
	logic [3:0]  yd3_s2;
	logic [9:0]  r1_s2;
	logic [3:0]  month_s2;
	logic [4:0]  date_s2;
	logic [2:0]  wday_s2;
	logic [4:0]  hour_s2;
	logic [5:0]  minute_s2;
	logic        ampm_s2;
	logic        pm_s2;
	logic [3:0]  sclip_s2;

	logic [3:0]  yh_c;
	logic [9:0]  hund_c;
	logic [6:0]  r2_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			kind_s2   <= kind_c;
			yd3_s2    <= (yk_c > 5'd9) ? 4'd9 : yk_c[3:0];
			r1_s2     <= r1_c;
			month_s2  <= month_s1;
			date_s2   <= date_s1;
			wday_s2   <= wday_s1;
			hour_s2   <= hsp_c;
			minute_s2 <= minute_s1;
			ampm_s2   <= mode_s1;
			pm_s2     <= pm_c;
			sclip_s2  <= sclip_c;
		end
	end

	always_comb begin
		yh_c   = '0;
		hund_c = '0;
		for (int k = 1; k <= 9; k++) begin
			if (r1_s2 >= 10'(k * 100)) begin
				yh_c   = 4'(k);
				hund_c = 10'(k * 100);
			end
		end
		r2_c = 7'(r1_s2 - hund_c);
	end

	// Stage 3: hundreds done, small fields split
	logic        valid_s3;
	scpb_kind_t  kind_s3;
	logic [3:0]  yd3_s3;
	logic [3:0]  yd2_s3;
	logic [6:0]  r2_s3;
	scpb_num_t   month_s3;
	scpb_num_t   date_s3;
	scpb_num_t   hour_s3;
	scpb_num_t   minute_s3;
	logic [2:0]  wday_s3;
	logic        ampm_s3;
	logic        pm_s3;
	logic [3:0]  sclip_s3;

	logic [3:0]  yt_c;
	logic [6:0]  tens_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			kind_s3   <= kind_s2;
			yd3_s3    <= yd3_s2;
			yd2_s3    <= yh_c;
			r2_s3     <= r2_c;
			month_s3  <= split_num({2'b00, month_s2});
			date_s3   <= split_num({1'b0, date_s2});
			hour_s3   <= split_num({1'b0, hour_s2});
			minute_s3 <= split_num(minute_s2);
			wday_s3   <= wday_s2;
			ampm_s3   <= ampm_s2;
			pm_s3     <= pm_s2;
			sclip_s3  <= sclip_s2;
		end
	end

	always_comb begin
		yt_c   = '0;
		tens_c = '0;
		for (int k = 1; k <= 9; k++) begin
			if (r2_s3 >= 7'(k * 10)) begin
				yt_c   = 4'(k);
				tens_c = 7'(k * 10);
			end
		end
		entry.kind     = kind_s3;
		entry.snd_clip = sclip_s3;
		entry.yd3      = yd3_s3;
		entry.yd2      = yd2_s3;
		entry.yd1      = yt_c;
		entry.yd0      = 4'(r2_s3 - tens_c);
		entry.month    = month_s3;
		entry.date     = date_s3;
		entry.hour     = hour_s3;
		entry.minute   = minute_s3;
		entry.wday     = wday_s3;
		entry.ampm     = ampm_s3;
		entry.pm       = pm_s3;
	end

	// drop requests with an unused function code
	assign push     = valid_s3 && (kind_s3 != KIND_NONE);
	assign inflight = 2'(valid_s1) + 2'(valid_s2) + 2'(valid_s3);

endmodule

// ===== hdl/scpb_queue.sv =====
// Descriptor queue between the front end and the clip sequencer.
// Small first-in first-out register array. Depends on scpb_pkg.
module scpb_queue import scpb_pkg::*; #(
	parameter int DEPTH = SCPB_QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  scpb_entry_t                wdata,
	input  logic                       pop,
	output scpb_entry_t                head,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	scpb_entry_t     slot_q [DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   count_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= bump(wptr_q);
			end
			if (pop) begin
				rptr_q <= bump(rptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign head  = slot_q[rptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CW'(DEPTH)) || pop)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue read while empty");

endmodule

// ===== hdl/scpb_back.sv =====
// Clip sequencer: walks one queued descriptor and emits one clip a cycle.
// Registered result outputs with a strobe. Depends on scpb_pkg.
module scpb_back import scpb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  scpb_entry_t head,
	output logic        pop,
	output logic        clip_strobe,
	output logic [2:0]  clip_folder,
	output logic [4:0]  clip_number,
	output logic        last_clip
);

	function automatic logic [4:0] dclip(input logic [3:0] d);
		return {1'b0, d} + 5'd1;
	endfunction

	// first step of a number group: tens digit from 20, "ten" from 10, else units
	function automatic scpb_step_t num_entry(input scpb_num_t n, input scpb_step_t st_t,
	                                         input scpb_step_t st_ten, input scpb_step_t st_u);
		if (n.t >= 3'd2) begin
			return st_t;
		end else if (n.t == 3'd1) begin
			return st_ten;
		end
		return st_u;
	endfunction

	logic        active_q;
	scpb_step_t  step_q;
	scpb_entry_t cur_q;

	logic        active_d;
	scpb_step_t  step_d;
	scpb_step_t  nxt;
	logic [2:0]  fold_c;
	logic [4:0]  num_c;
	logic        last_c;
	logic        load;

	logic        strobe_q;
	logic [2:0]  folder_q;
	logic [4:0]  number_q;
	logic        last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q   <= STEP_SOUND;
		end else begin
			active_q <= active_d;
			step_q   <= step_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= head;
		end
	end

	always_comb begin
		fold_c = FOLD_WORDS;
		num_c  = W_PAUSE;
		last_c = 1'b0;
		nxt    = step_q;
		case (step_q)
			STEP_SOUND: begin
				fold_c = (cur_q.kind == KIND_ALARM) ? FOLD_ALARM : FOLD_EFFECT;
				num_c  = {1'b0, cur_q.snd_clip};
				last_c = 1'b1;
			end
			STEP_NOW: begin
				num_c = W_NOW;
				nxt   = STEP_P0;
			end
			STEP_P0: nxt = STEP_Y3;
			STEP_Y3: begin
				fold_c = FOLD_DIGITS;
				num_c  = dclip(cur_q.yd3);
				nxt    = STEP_Y2;
			end
			STEP_Y2: begin
				fold_c = FOLD_DIGITS;
				num_c  = dclip(cur_q.yd2);
				nxt    = STEP_Y1;
			end
			STEP_Y1: begin
				fold_c = FOLD_DIGITS;
				num_c  = dclip(cur_q.yd1);
				nxt    = STEP_Y0;
			end
			STEP_Y0: begin
				fold_c = FOLD_DIGITS;
				num_c  = dclip(cur_q.yd0);
				nxt    = STEP_YEARW;
			end
			STEP_YEARW: begin
				num_c = W_YEAR;
				nxt   = num_entry(cur_q.month, STEP_MON_T, STEP_MON_TEN, STEP_MON_U);
			end
			STEP_MON_T: begin
				fold_c = FOLD_DIGITS;
				num_c  = dclip({1'b0, cur_q.month.t});
				nxt    = STEP_MON_TEN;
			end
			STEP_MON_TEN: begin
				fold_c = FOLD_TENS;
				num_c  = T_TEN;
				nxt    = (cur_q.month.u != 4'd0) ? STEP_MON_U : STEP_MONW;
			end
			STEP_MON_U: begin
				fold_c = FOLD_DIGITS;
				num_c  = dclip(cur_q.month.u);
				nxt    = STEP_MONW;
			end
			STEP_MONW: begin
				num_c = W_MONTH;
				nxt   = num_entry(cur_q.date, STEP_DAT_T, STEP_DAT_TEN, STEP_DAT_U);
			end
			STEP_DAT_T: begin
				fold_c = FOLD_DIGITS;
				num_c  = dclip({1'b0, cur_q.date.t});
				nxt    = STEP_DAT_TEN;
			end
			STEP_DAT_TEN: begin
				fold_c = FOLD_TENS;
				num_c  = T_TEN;
				nxt    = (cur_q.date.u != 4'd0) ? STEP_DAT_U : STEP_DAYW;
			end
			STEP_DAT_U: begin
				fold_c = FOLD_DIGITS;
				num_c  = dclip(cur_q.date.u);
				nxt    = STEP_DAYW;
			end
			STEP_DAYW: begin
				num_c = W_DAY;
				nxt   = STEP_P1;
			end
			STEP_P1: nxt = STEP_WEEK;
			STEP_WEEK: begin
				num_c = W_WEEK;
				nxt   = STEP_WDAY;
			end
			STEP_WDAY: begin
				// Sunday speaks the "day" word
				if (cur_q.wday == 3'd7) begin
					num_c = W_DAY;
				end else begin
					fold_c = FOLD_DIGITS;
					num_c  = dclip({1'b0, cur_q.wday});
				end
				nxt = STEP_P2;
			end
			STEP_P2: begin
				nxt = cur_q.ampm ? STEP_AMPM
				                 : num_entry(cur_q.hour, STEP_HR_T, STEP_HR_TEN, STEP_HR_U);
			end
			STEP_AMPM: begin
				num_c = cur_q.pm ? W_AFTERNOON : W_MORNING;
				nxt   = num_entry(cur_q.hour, STEP_HR_T, STEP_HR_TEN, STEP_HR_U);
			end
			STEP_HR_T: begin
				fold_c = FOLD_DIGITS;
				num_c  = dclip({1'b0, cur_q.hour.t});
				nxt    = STEP_HR_TEN;
			end
			STEP_HR_TEN: begin
				fold_c = FOLD_TENS;
				num_c  = T_TEN;
				nxt    = (cur_q.hour.u != 4'd0) ? STEP_HR_U : STEP_DIAN;
			end
			STEP_HR_U: begin
				fold_c = FOLD_DIGITS;
				num_c  = dclip(cur_q.hour.u);
				nxt    = STEP_DIAN;
			end
			STEP_DIAN: begin
				num_c = W_DIAN;
				if (cur_q.minute.t == 3'd0 && cur_q.minute.u == 4'd0) begin
					nxt = STEP_WHOLE;
				end else if (cur_q.minute.t == 3'd0) begin
					nxt = STEP_MIN_Z;
				end else begin
					nxt = num_entry(cur_q.minute, STEP_MIN_T, STEP_MIN_TEN, STEP_MIN_U);
				end
			end
			STEP_WHOLE: begin
				num_c = W_WHOLE;
				nxt   = STEP_P3;
			end
			STEP_MIN_Z: begin
				// leading zero for minutes one to nine
				fold_c = FOLD_DIGITS;
				num_c  = dclip(4'd0);
				nxt    = STEP_MIN_U;
			end
			STEP_MIN_T: begin
				fold_c = FOLD_DIGITS;
				num_c  = dclip({1'b0, cur_q.minute.t});
				nxt    = STEP_MIN_TEN;
			end
			STEP_MIN_TEN: begin
				fold_c = FOLD_TENS;
				num_c  = T_TEN;
				nxt    = (cur_q.minute.u != 4'd0) ? STEP_MIN_U : STEP_MINW;
			end
			STEP_MIN_U: begin
				fold_c = FOLD_DIGITS;
				num_c  = dclip(cur_q.minute.u);
				nxt    = STEP_MINW;
			end
			STEP_MINW: begin
				num_c = W_MINUTE;
				nxt   = STEP_P3;
			end
			STEP_P3: last_c = 1'b1;
			default: last_c = 1'b1;
		endcase

		// take the next descriptor when idle or on the last clip of this one
		load     = (!active_q || last_c) && !empty;
		active_d = active_q;
		step_d   = step_q;
		if (load) begin
			active_d = 1'b1;
			step_d   = (head.kind == KIND_ANNOUNCE) ? STEP_NOW : STEP_SOUND;
		end else if (active_q && last_c) begin
			active_d = 1'b0;
		end else if (active_q) begin
			step_d = nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		folder_q <= fold_c;
		number_q <= num_c;
		last_q   <= last_c;
	end

	assign pop         = load;
	assign clip_strobe = strobe_q;
	assign clip_folder = folder_q;
	assign clip_number = number_q;
	assign last_clip   = strobe_q && last_q;

	a_phrase_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && !last_q) |=> strobe_q)
		else $error("gap inside a phrase");

	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && !last_c) |-> !load)
		else $error("descriptor taken while a phrase is running");

endmodule

// ===== hdl/spoken_clock_phrase_builder_core.sv =====
// Top level of the spoken clock phrase builder.
// Instantiates scpb_front, scpb_queue and scpb_back; depends on scpb_pkg.
//
// Usage:
//   Request channel: a request is taken at a rising edge with start high and
//   busy low. func 0 announces the date and time, 1 and 2 play one alarm or
//   effect clip, 3 is accepted and yields nothing.
//   Result channel: each clip code (clip_folder, clip_number) shows for one
//   cycle with clip_strobe high; last_clip marks the final clip of a phrase.
//   The receiver cannot stall; clips leave at one per cycle.
//   Configuration: cfg_data[0] sets twelve_hour_mode on a cfg_valid and
//   cfg_ready transfer; cfg_ready is always high. Write it only while idle.
// Timing:
//   The first clip passes three front stages, the queue, the sequencer state
//   register and the sequencer output register. A phrase then streams one
//   clip per cycle: 1 clip for a sound, up to 27 for an announce. The
//   sequencer stepping one clip a cycle sets the sustained rate; the queue
//   lets new requests be taken every cycle until DEPTH requests are pending.
// Reset:
//   arst_n clears the pipeline, queue and sequencer and sets 24-hour mode.
module spoken_clock_phrase_builder_core import scpb_pkg::*; #(
	parameter int DEPTH = SCPB_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [13:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day_of_month,
	input  logic [2:0]  weekday,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [7:0]  sound_index,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	output logic        clip_strobe,
	output logic [2:0]  clip_folder,
	output logic [4:0]  clip_number,
	output logic        last_clip
);

	localparam int CW = $clog2(DEPTH + 1);

	logic              mode_q;
	logic              accept;
	logic              push;
	logic              pop;
	logic              empty;
	logic [1:0]        inflight;
	logic [CW-1:0]     count;
	logic [CW+1:0]     occupancy;
	scpb_entry_t       fe_entry;
	scpb_entry_t       head;

	// Hold the mode register; always ready for a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	// Reserve a queue slot for every request still in the front stages
	assign occupancy = (CW + 2)'(count) + (CW + 2)'(inflight);
	assign busy      = (occupancy >= (CW + 2)'(DEPTH));
	assign accept    = start && !busy;

	scpb_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.func             (func),
		.year             (year),
		.month            (month),
		.day_of_month     (day_of_month),
		.weekday          (weekday),
		.hour             (hour),
		.minute           (minute),
		.sound_index      (sound_index),
		.twelve_hour_mode (mode_q),
		.push             (push),
		.entry            (fe_entry),
		.inflight         (inflight)
	);

	scpb_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (fe_entry),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.count  (count)
	);

	scpb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.head        (head),
		.pop         (pop),
		.clip_strobe (clip_strobe),
		.clip_folder (clip_folder),
		.clip_number (clip_number),
		.last_clip   (last_clip)
	);

	a_busy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= (CW + 2)'(DEPTH))
		else $error("more requests pending than queue slots");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for spoken_clock_phrase_builder_core: drives announce and sound
// requests, predicts each spoken clip sequence and checks every strobed clip.
// Depends on scpb_pkg and the core RTL only.
module tb_top;
	import scpb_pkg::*;

	// func value that the core accepts but never speaks
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// Cycles to let pass after the last expected clip before touching the mode
	// register or ending the run: a silent request may still be in the front
	// stages of the pipe.
	localparam int DRAIN_CYCLES = 12;

	typedef struct {
		logic [1:0]  func;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [2:0]  weekday;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [7:0]  sound_index;
	} request_t;

	typedef struct {
		logic [2:0] folder;
		logic [4:0] number;
		logic       last;
	} clip_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  func = '0;
	logic [13:0] year = '0;
	logic [3:0]  month = '0;
	logic [4:0]  day_of_month = '0;
	logic [2:0]  weekday = '0;
	logic [4:0]  hour = '0;
	logic [5:0]  minute = '0;
	logic [7:0]  sound_index = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	logic        clip_strobe;
	logic [2:0]  clip_folder;
	logic [4:0]  clip_number;
	logic        last_clip;

	spoken_clock_phrase_builder_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.weekday      (weekday),
		.hour         (hour),
		.minute       (minute),
		.sound_index  (sound_index),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.clip_strobe  (clip_strobe),
		.clip_folder  (clip_folder),
		.clip_number  (clip_number),
		.last_clip    (last_clip)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Requests waiting for the driver, and clips still owed by the core
	request_t pending_requests[$];
	clip_t    spoken_clips_q[$];
	int       requests_open = 0;   // queued but not yet transferred
	int       fail_count = 0;
	logic     twelve_hour_shadow = 1'b0;

	// ------------------------------------------------------------------
	// Phrase prediction: append the clips a request is expected to speak
	// ------------------------------------------------------------------
	function automatic void put_clip(logic [2:0] f, logic [4:0] n);
		clip_t c;
		c.folder = f;
		c.number = n;
		c.last   = 1'b0;
		spoken_clips_q.push_back(c);
	endfunction

	// Single digits above nine cannot be spoken; they saturate at nine
	function automatic void put_digit(int unsigned d);
		if (d > 9)
			d = 9;
		put_clip(FOLD_DIGITS, 5'(d + 1));
	endfunction

	// Chinese reading: 0-9 one digit, 10-19 "ten" + units, 20+ tens "ten" units
	function automatic void put_number(int unsigned n);
		if (n <= 9) begin
			put_digit(n);
		end else begin
			if (n >= 20)
				put_digit(n / 10);
			put_clip(FOLD_TENS, T_TEN);
			if (n % 10 != 0)
				put_digit(n % 10);
		end
	endfunction

	function automatic void build_phrase(request_t r, logic twelve_hour);
		int unsigned y;
		int unsigned h;
		int unsigned h12;
		int          size_before;
		clip_t       tail;
		size_before = spoken_clips_q.size();
		y = r.year;
		h = r.hour;
		if (r.func == FUNC_ALARM || r.func == FUNC_EFFECT) begin
			// Sound index is clamped to the tenth clip
			put_clip((r.func == FUNC_ALARM) ? FOLD_ALARM : FOLD_EFFECT,
				(r.sound_index > 8'd9) ? 5'd10 : 5'(r.sound_index + 8'd1));
		end else if (r.func == FUNC_ANNOUNCE) begin
			put_clip(FOLD_WORDS, W_NOW);
			put_clip(FOLD_WORDS, W_PAUSE);
			put_digit(y / 1000);
			put_digit((y % 1000) / 100);
			put_digit((y % 100) / 10);
			put_digit(y % 10);
			put_clip(FOLD_WORDS, W_YEAR);
			put_number(r.month);
			put_clip(FOLD_WORDS, W_MONTH);
			put_number(r.day_of_month);
			put_clip(FOLD_WORDS, W_DAY);
			put_clip(FOLD_WORDS, W_PAUSE);
			put_clip(FOLD_WORDS, W_WEEK);
			// Sunday is spoken with the "day" word, not a digit
			if (r.weekday == 3'd7)
				put_clip(FOLD_WORDS, W_DAY);
			else
				put_digit(r.weekday);
			put_clip(FOLD_WORDS, W_PAUSE);
			if (twelve_hour) begin
				if (h == 0)
					h12 = 12;
				else if (h <= 12)
					h12 = h;
				else
					h12 = h - 12;
				put_clip(FOLD_WORDS, (h >= 12) ? W_AFTERNOON : W_MORNING);
				put_number(h12);
			end else begin
				put_number(h);
			end
			put_clip(FOLD_WORDS, W_DIAN);
			if (r.minute == 6'd0) begin
				put_clip(FOLD_WORDS, W_WHOLE);
			end else begin
				// Minutes one to nine get a leading "zero"
				if (r.minute <= 6'd9)
					put_digit(0);
				put_number(r.minute);
				put_clip(FOLD_WORDS, W_MINUTE);
			end
			put_clip(FOLD_WORDS, W_PAUSE);
		end
		// Mark the final clip of the phrase; the unused func speaks nothing
		if (spoken_clips_q.size() > size_before) begin
			tail = spoken_clips_q.pop_back();
			tail.last = 1'b1;
			spoken_clips_q.push_back(tail);
		end
	endfunction

	// ------------------------------------------------------------------
	// Request driver: bursts of back-to-back requests with random gaps
	// ------------------------------------------------------------------
	request_t on_port;
	int       burst_left = 0;
	int       gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && busy)) begin
			// A transfer happened at this edge: predict its phrase now
			if (start) begin
				build_phrase(on_port, twelve_hour_shadow);
				requests_open--;
			end
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				on_port = pending_requests.pop_front();
				func         <= on_port.func;
				year         <= on_port.year;
				month        <= on_port.month;
				day_of_month <= on_port.day_of_month;
				weekday      <= on_port.weekday;
				hour         <= on_port.hour;
				minute       <= on_port.minute;
				sound_index  <= on_port.sound_index;
				start        <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					// Start a new burst; sometimes no gap, sometimes a long one
					burst_left = $urandom_range(0, 12);
					case ($urandom_range(0, 5))
						0, 1: gap_left = 0;
						2: gap_left = $urandom_range(20, 60);
						default: gap_left = $urandom_range(1, 6);
					endcase
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Clip monitor: every strobed clip must match the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		clip_t want;
		if (arst_n && clip_strobe) begin
			if (spoken_clips_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: unexpected clip folder=%0d number=%0d last=%0b",
						$realtime, clip_folder, clip_number, last_clip);
			end else begin
				want = spoken_clips_q.pop_front();
				if (clip_folder !== want.folder || clip_number !== want.number ||
						last_clip !== want.last) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: clip mismatch exp %0d/%0d/%0b got %0d/%0d/%0b",
							$realtime, want.folder, want.number, want.last,
							clip_folder, clip_number, last_clip);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic request_t make_announce(int unsigned y, int unsigned mo,
			int unsigned d, int unsigned wd, int unsigned h, int unsigned mi);
		request_t r;
		r.func         = FUNC_ANNOUNCE;
		r.year         = 14'(y);
		r.month        = 4'(mo);
		r.day_of_month = 5'(d);
		r.weekday      = 3'(wd);
		r.hour         = 5'(h);
		r.minute       = 6'(mi);
		r.sound_index  = 8'($urandom);
		return r;
	endfunction

	function automatic request_t make_sound(logic [1:0] f, int unsigned idx);
		request_t r;
		r = make_announce($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		r.func        = f;
		r.sound_index = 8'(idx);
		return r;
	endfunction

	// Mostly well-formed announces, some sounds, and raw noise over full widths
	function automatic request_t random_request();
		request_t r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			r = make_announce($urandom_range(0, 9999), $urandom_range(1, 12),
				$urandom_range(1, 31), $urandom_range(1, 7),
				$urandom_range(0, 23), $urandom_range(0, 59));
		end else if (pick < 85) begin
			r = make_sound(2'($urandom_range(1, 2)),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12));
		end else begin
			r = make_sound(2'($urandom), $urandom);
		end
		return r;
	endfunction

	task automatic queue_request(request_t r);
		requests_open++;
		pending_requests.push_back(r);
	endtask

	// Hold until every request has transferred and every clip came out,
	// then let the pipe go quiet
	task automatic wait_drained();
		do
			@(negedge clk);
		while (requests_open != 0 || spoken_clips_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// One transfer on the configuration channel; only called while idle
	task automatic write_mode(logic twelve_hour);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= twelve_hour;
		do
			@(posedge clk);
		while (!cfg_ready);
		twelve_hour_shadow = twelve_hour;
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_phase(int n_items);
		request_t r;
		int       spoken;
		spoken = 0;
		// Silent requests do not count toward the phase size
		while (spoken < n_items) begin
			r = random_request();
			if (r.func != FUNC_UNUSED)
				spoken++;
			queue_request(r);
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : run_sequence
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// 24-hour mode straight out of reset: field extremes and number forms
		queue_request(make_announce(0, 1, 1, 1, 0, 0));
		queue_request(make_announce(9999, 12, 31, 7, 23, 59));
		// Year above 9999 saturates its thousands digit; out-of-range fields
		queue_request(make_announce(16383, 15, 31, 0, 31, 63));
		queue_request(make_announce(2024, 10, 19, 3, 10, 5));
		queue_request(make_announce(1987, 9, 20, 6, 19, 10));
		queue_request(make_announce(2000, 11, 0, 5, 20, 19));
		queue_request(make_announce(5050, 0, 30, 4, 12, 20));
		queue_request(make_sound(FUNC_ALARM, 0));
		queue_request(make_sound(FUNC_ALARM, 9));
		queue_request(make_sound(FUNC_ALARM, 10));
		queue_request(make_sound(FUNC_EFFECT, 0));
		queue_request(make_sound(FUNC_EFFECT, 255));
		queue_request(make_sound(FUNC_UNUSED, 3));
		queue_request(make_announce(1234, 2, 2, 2, 1, 1));
		wait_drained();

		// 12-hour mode: midnight, morning, noon, afternoon, out-of-range hours
		write_mode(1'b1);
		queue_request(make_announce(2023, 6, 15, 7, 0, 0));
		queue_request(make_announce(2023, 6, 15, 1, 11, 9));
		queue_request(make_announce(2023, 6, 15, 2, 12, 30));
		queue_request(make_announce(2023, 6, 15, 3, 13, 45));
		queue_request(make_announce(2023, 6, 15, 4, 23, 59));
		queue_request(make_announce(2023, 6, 15, 5, 24, 1));
		queue_request(make_announce(2023, 6, 15, 6, 31, 0));
		queue_request(make_sound(FUNC_EFFECT, 7));
		wait_drained();

		// Random traffic, flipping the clock mode between phases
		random_phase(95);
		wait_drained();
		write_mode(1'b0);
		random_phase(95);
		wait_drained();
		write_mode(1'b1);
		random_phase(95);
		wait_drained();
		write_mode(1'b0);
		random_phase(95);
		wait_drained();

		if (fail_count == 0 && spoken_clips_q.size() == 0)
			$display("[spoken_clock_phrase_builder_core] OK");
		else
			$display("[spoken_clock_phrase_builder_core] ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin : watchdog
		#(2_000_000);
		$display("[spoken_clock_phrase_builder_core] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/scpb_pkg.sv
hdl/scpb_front.sv
hdl/scpb_queue.sv
hdl/scpb_back.sv
hdl/spoken_clock_phrase_builder_core.sv
tb/sv/tb_top.sv
